@@ hdl/swma_pkg.sv @@
package swma_pkg;

    // default depth of the sample ring
    localparam int MAX_WINDOW_DEF = 1024;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int AVG_W    = 24;
    localparam int WIN_W    = 11;
    localparam int FRAC_W   = 8;

    // register file
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = '0;
    localparam logic [WIN_W-1:0]     WINDOW_RESET    = 11'd1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV
    } swma_state_t;

    // divider handshake
    typedef struct packed {
        logic start;
        logic take;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ hdl/swma_ram.sv @@
module swma_ram #(
    parameter int WIDTH = swma_pkg::SAMPLE_W,
    parameter int DEPTH = swma_pkg::MAX_WINDOW_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/swma_div.sv @@
module swma_div #(
    parameter int DVD_W = 35,
    parameter int DVS_W = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swma_pkg::div_req_t    req,
    input  logic [DVD_W-1:0]      dividend,
    input  logic [DVS_W-1:0]      divisor,
    output swma_pkg::div_stat_t   stat,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] dvd_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             q_bit;

    // one restoring step: bring down the next dividend bit
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        q_bit    = (trial >= {1'b0, dvs_reg});
        rem_next = q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        dvd_next = {dvd_reg[DVD_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else if (req.take)
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

@@ hdl/sliding_window_moving_average.sv @@
// one sample at a time: a new sample is taken only once the previous average
//   has left the divider for the output stage; the bit-serial divider
//   retires one quotient bit per cycle
// reset: window_size returns to 1024, sum, fill count and write pointer clear;
//   ring contents are not cleared, the fill count masks unwritten entries
module sliding_window_moving_average #(
    parameter int MAX_WINDOW = swma_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swma_pkg::PADDR_W-1:0]        paddr,
    input  logic [swma_pkg::PDATA_W-1:0]        pwdata,
    output logic [swma_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [swma_pkg::SAMPLE_W-1:0] sample,
    // result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [swma_pkg::AVG_W-1:0]   average_q8,
    output logic [swma_pkg::WIN_W-1:0]          samples_held
);

    // ring address and fill count widths follow the ring depth
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    // worst case sum is MAX_WINDOW full-scale samples, plus headroom
    localparam int SUM_W = AW + 17;
    // dividend is the magnitude of the sum shifted up by the fraction bits
    localparam int DVD_W = SUM_W + swma_pkg::FRAC_W;

    localparam int SW = swma_pkg::SAMPLE_W;

    swma_pkg::swma_state_t state_reg;
    swma_pkg::swma_state_t state_next;

    logic [swma_pkg::WIN_W-1:0]  ws_reg;
    logic [AW-1:0]               pos_reg;
    logic [AW-1:0]               pos_next;
    logic [CW-1:0]               fill_reg;
    logic [CW-1:0]               fill_next;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [SUM_W-1:0]     sum_next;
    logic signed [SW-1:0]        sample_reg;
    logic                        neg_reg;
    logic [CW-1:0]               held_reg;

    logic signed [swma_pkg::AVG_W-1:0] avg_out_reg;
    logic [swma_pkg::WIN_W-1:0]        held_out_reg;
    logic                              out_valid_reg;

    logic [CW-1:0]               eff_win;
    logic [CW-1:0]               pos_inc;
    logic                        ring_full;
    logic signed [SW-1:0]        old_sample;
    logic [SUM_W-1:0]            sum_abs;
    logic [SW-1:0]               ram_rdata;

    logic [swma_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_wr;

    logic                        sample_acc;
    logic                        ram_we;
    logic                        load_out;
    swma_pkg::div_req_t          div_req;
    swma_pkg::div_stat_t         div_stat;
    logic [DVD_W-1:0]            quotient;
    logic [DVD_W-1:0]            q_signed;

    // ------------------------------------------------------------------
    // register file: a write of window_size restarts the averaging
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[2 +: swma_pkg::REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (reg_idx == swma_pkg::REG_WINDOW_SIZE);

    always_comb
    begin
        unique case (reg_idx)
            swma_pkg::REG_WINDOW_SIZE: prdata = swma_pkg::PDATA_W'(ws_reg);
            default:                   prdata = '0;
        endcase
    end

    // zero acts as one, anything above the ring depth is clipped to it
    always_comb
    begin
        if (ws_reg == '0)
        begin
            eff_win = CW'(1);
        end
        else if (32'(ws_reg) > 32'(MAX_WINDOW))
        begin
            eff_win = CW'(MAX_WINDOW);
        end
        else
        begin
            eff_win = CW'(ws_reg);
        end
    end

    // ------------------------------------------------------------------
    // sample ring: read the oldest entry on acceptance in IDLE, overwrite it
    // in ACC; the two never touch the same entry in one cycle
    // ------------------------------------------------------------------
    swma_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .re    (sample_acc),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // until the window has filled, the entry under the pointer was never
    // written since the last restart and counts as zero
    assign ring_full  = (fill_reg == eff_win);
    assign old_sample = ring_full ? $signed(ram_rdata) : '0;

    always_comb
    begin
        sum_next  = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
        pos_inc   = CW'(pos_reg) + CW'(1);
        pos_next  = (pos_inc == eff_win) ? '0 : AW'(pos_inc);
        fill_next = ring_full ? fill_reg : fill_reg + CW'(1);
        sum_abs   = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    end

    // ------------------------------------------------------------------
    // control sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swma_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = swma_pkg::ST_ACC;
                end
            end
            swma_pkg::ST_ACC:
            begin
                state_next = swma_pkg::ST_DIV;
            end
            swma_pkg::ST_DIV:
            begin
                if (load_out)
                begin
                    state_next = swma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sample_ready  = 1'b0;
        ram_we        = 1'b0;
        div_req.start = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            swma_pkg::ST_IDLE:
            begin
                sample_ready = 1'b1;
            end
            swma_pkg::ST_ACC:
            begin
                ram_we        = 1'b1;
                div_req.start = 1'b1;
            end
            swma_pkg::ST_DIV:
            begin
                // result leaves as soon as the output stage is free
                load_out = div_stat.done && (!out_valid_reg || result_ready);
            end
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
        div_req.take = load_out;
    end

    assign sample_acc   = sample_valid && sample_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swma_pkg::ST_IDLE;
            ws_reg    <= swma_pkg::WINDOW_RESET;
            pos_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                ws_reg   <= pwdata[swma_pkg::WIN_W-1:0];
                pos_reg  <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end
            else if (state_reg == swma_pkg::ST_ACC)
            begin
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            sample_reg <= sample;
        end
        if (state_reg == swma_pkg::ST_ACC)
        begin
            neg_reg  <= sum_next[SUM_W-1];
            held_reg <= fill_next;
        end
    end

    // ------------------------------------------------------------------
    // bit-serial divide of |sum| * 256 by the fill count
    // ------------------------------------------------------------------
    swma_div #(
        .DVD_W (DVD_W),
        .DVS_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend ({sum_abs, {swma_pkg::FRAC_W{1'b0}}}),
        .divisor  (fill_next),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // magnitude division gives truncation toward zero once the sign returns
    assign q_signed = neg_reg ? DVD_W'(-quotient) : quotient;

    // ------------------------------------------------------------------
    // output stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            avg_out_reg  <= $signed(q_signed[swma_pkg::AVG_W-1:0]);
            held_out_reg <= swma_pkg::WIN_W'(held_reg);
        end
    end

    assign result_valid = out_valid_reg;
    assign average_q8   = avg_out_reg;
    assign samples_held = held_out_reg;

`ifndef SYNTHESIS
    // fill count never passes the effective window
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= eff_win)
        else $error("fill count beyond window");

    // write pointer stays inside the effective window
    assert property (@(posedge clk) disable iff (!rst_n)
        CW'(pos_reg) < eff_win)
        else $error("write pointer outside window");

    // a new sample is only taken with the divider free
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready |-> (!div_stat.busy && !div_stat.done))
        else $error("sample taken while divider occupied");

    // an accepted sample passes through ACC, whose start request makes the divider busy
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_acc |=> ##1 div_stat.busy)
        else $error("divider not started after sample");
`endif

endmodule

@@ dv/sliding_window_moving_average_tb.sv @@
`timescale 1ns / 100ps

module sliding_window_moving_average_tb;

    // byte addresses on the configuration port
    localparam logic [swma_pkg::PADDR_W-1:0] ADDR_WINDOW_SIZE =
        swma_pkg::PADDR_W'(swma_pkg::REG_WINDOW_SIZE) << 2;
    // first address past the register file, writes here must be dropped
    localparam logic [swma_pkg::PADDR_W-1:0] ADDR_UNMAPPED =
        ADDR_WINDOW_SIZE + swma_pkg::PADDR_W'(4);

    localparam int RANDOM_ITEMS = 1225;
    localparam int BIG_BURST    = 1040;
    localparam int MAX_GAP      = 10;
    localparam int SETTLE_WAIT  = 64;

    typedef struct packed {
        logic signed [swma_pkg::AVG_W-1:0] avg;
        logic [swma_pkg::WIN_W-1:0]        held;
    } mean_result_t;

    // running boxcar mean with its own copy of the window state
    class boxcar_checker;
        logic [swma_pkg::WIN_W-1:0]           window_reg;
        logic signed [swma_pkg::SAMPLE_W-1:0] ring [swma_pkg::MAX_WINDOW_DEF];
        int unsigned                          wr_ptr;
        int unsigned                          fill;
        longint                               window_sum;
        mean_result_t                         expected_means[$];
        int                                   mismatches;

        function new();
            mismatches = 0;
            window_reg = swma_pkg::WINDOW_RESET;
            restart();
        endfunction

        function void restart();
            foreach (ring[i])
                ring[i] = '0;
            wr_ptr     = 0;
            fill       = 0;
            window_sum = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        // any write to the window register restarts averaging, other addresses are dropped
        function void write_register(logic [swma_pkg::PADDR_W-1:0] addr,
                                     logic [swma_pkg::PDATA_W-1:0] value);
            if (addr[swma_pkg::PADDR_W-1:2] == swma_pkg::REG_WINDOW_SIZE)
            begin
                window_reg = value[swma_pkg::WIN_W-1:0];
                restart();
            end
        endfunction

        function void check_readback(logic [swma_pkg::PDATA_W-1:0] data);
            if (data !== swma_pkg::PDATA_W'(window_reg))
                flag($sformatf("window_size readback expected %0d, got %0d",
                               window_reg, data));
        endfunction

        function void note_sample(logic signed [swma_pkg::SAMPLE_W-1:0] s);
            int unsigned  eff;
            int unsigned  pos;
            longint       mean;
            mean_result_t r;
            // zero behaves as one, oversize clamps to the ring depth
            if (window_reg == 0)
                eff = 1;
            else if (window_reg > swma_pkg::MAX_WINDOW_DEF)
                eff = swma_pkg::MAX_WINDOW_DEF;
            else
                eff = window_reg;
            pos = (wr_ptr >= eff) ? 0 : wr_ptr;
            window_sum = window_sum - ring[pos] + s;
            ring[pos]  = s;
            wr_ptr     = (pos + 1 >= eff) ? 0 : pos + 1;
            if (fill < eff)
                fill++;
            mean   = (window_sum * 256) / longint'(fill);
            r.avg  = mean[swma_pkg::AVG_W-1:0];
            r.held = fill[swma_pkg::WIN_W-1:0];
            expected_means = {expected_means, r};
        endfunction

        function void check_result(logic signed [swma_pkg::AVG_W-1:0] avg,
                                   logic [swma_pkg::WIN_W-1:0] held);
            mean_result_t e;
            if (expected_means.size() == 0)
            begin
                flag($sformatf("result with no sample outstanding: average_q8 %0d held %0d",
                               avg, held));
                return;
            end
            e = expected_means.pop_front();
            if (avg !== e.avg)
                flag($sformatf("average_q8 expected %0d, got %0d", e.avg, avg));
            if (held !== e.held)
                flag($sformatf("samples_held expected %0d, got %0d", e.held, held));
        endfunction
    endclass

    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 psel         = 1'b0;
    logic                                 penable      = 1'b0;
    logic                                 pwrite       = 1'b0;
    logic [swma_pkg::PADDR_W-1:0]         paddr        = '0;
    logic [swma_pkg::PDATA_W-1:0]         pwdata       = '0;
    logic [swma_pkg::PDATA_W-1:0]         prdata;
    logic                                 pready;
    logic                                 sample_valid = 1'b0;
    logic                                 sample_ready;
    logic signed [swma_pkg::SAMPLE_W-1:0] sample       = '0;
    logic                                 result_valid;
    logic                                 result_ready = 1'b1;
    logic signed [swma_pkg::AVG_W-1:0]    average_q8;
    logic [swma_pkg::WIN_W-1:0]           samples_held;

    boxcar_checker boxcar;

    // idling switches, flipped per phase so some stretches run flat out
    bit send_idle  = 1'b0;
    bit recv_idle  = 1'b0;
    int stall_left = 0;

    sliding_window_moving_average #(
        .MAX_WINDOW   (swma_pkg::MAX_WINDOW_DEF)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .average_q8   (average_q8),
        .samples_held (samples_held)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap(bit idle_on);
        return idle_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // extremes and small values weighted up, the rest uniform over 16 bits
    function automatic logic signed [swma_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return swma_pkg::SAMPLE_W'($urandom_range(0, 31)) - 16'sd16;
            default: return swma_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    // one sample transaction; called just after a rising edge, returns on the accepting edge
    // valid is left high so a zero gap runs straight into the next transaction
    task automatic send_sample(input logic signed [swma_pkg::SAMPLE_W-1:0] value);
        int gap;
        gap = draw_gap(send_idle);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        do
            @(posedge clk);
        while (!sample_ready);
        boxcar.note_sample(value);
    endtask

    // drop valid and let every outstanding average come back before touching config
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (boxcar.expected_means.size() != 0)
            @(posedge clk);
    endtask

    // setup then access phase; penable is dropped at the end but psel is left to the caller
    task automatic apb_xfer(input bit is_write, input logic [swma_pkg::PADDR_W-1:0] addr,
                            input logic [swma_pkg::PDATA_W-1:0] wdata,
                            output logic [swma_pkg::PDATA_W-1:0] rdata);
        psel   <= 1'b1;
        pwrite <= is_write;
        paddr  <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        penable <= 1'b0;
    endtask

    // register write followed by a readback of window_size
    task automatic write_register(input logic [swma_pkg::PADDR_W-1:0] addr,
                                  input logic [swma_pkg::PDATA_W-1:0] value);
        logic [swma_pkg::PDATA_W-1:0] rd;
        apb_xfer(1'b1, addr, value, rd);
        boxcar.write_register(addr, value);
        apb_xfer(1'b0, ADDR_WINDOW_SIZE, '0, rd);
        psel <= 1'b0;
        boxcar.check_readback(rd);
    endtask

    // result side: check every transaction, then hold ready low for a drawn stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                boxcar.check_result(average_q8, samples_held);
                stall_left = draw_gap(recv_idle);
                if (stall_left > 0)
                    result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    result_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int                         sent;
        int                         n;
        int                         kind;
        logic [swma_pkg::WIN_W-1:0] w;
        boxcar = new();
        sent   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset window of 1024, full-scale and sign-boundary samples
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        drain_results();

        // window of one, mean equals the sample
        write_register(ADDR_WINDOW_SIZE, 32'd1);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        drain_results();

        // write past the register file must not disturb the window
        write_register(ADDR_UNMAPPED, 32'd3);
        send_sample(16'sd5);
        send_sample(-16'sd5);
        drain_results();

        // zero window behaves as one
        write_register(ADDR_WINDOW_SIZE, 32'd0);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        drain_results();

        // saturated window at both ends of the range
        write_register(ADDR_WINDOW_SIZE, 32'd3);
        repeat (4) send_sample(16'sh7FFF);
        drain_results();
        // rewriting the same size still clears the history
        write_register(ADDR_WINDOW_SIZE, 32'd3);
        repeat (4) send_sample(16'sh8000);
        drain_results();

        // oversize window clamps to the ring depth
        write_register(ADDR_WINDOW_SIZE, 32'hFFFF_F7FF);
        send_sample(16'sd7);
        send_sample(-16'sd3);
        drain_results();

        // random phases, one long run at full depth to wrap and saturate the fill count
        for (int p = 0; sent < RANDOM_ITEMS; p++)
        begin
            kind = (p == 2) ? 6 : $urandom_range(0, 5);
            case (kind)
                0:       w = swma_pkg::WIN_W'($urandom_range(1, 8));
                1:       w = swma_pkg::WIN_W'($urandom_range(9, 64));
                2:       w = '0;
                3:       w = swma_pkg::WIN_W'($urandom_range(swma_pkg::MAX_WINDOW_DEF + 1,
                                                             2047));
                4:       w = swma_pkg::WIN_W'($urandom_range(0, 2047));
                5:       w = boxcar.window_reg;
                default: w = $urandom_range(0, 1) ? swma_pkg::WIN_W'(swma_pkg::MAX_WINDOW_DEF)
                                                  : '1;
            endcase
            // upper data bits are noise, only the low 11 bits are kept
            write_register(ADDR_WINDOW_SIZE,
                           {(swma_pkg::PDATA_W - swma_pkg::WIN_W)'($urandom()), w});
            if ($urandom_range(0, 3) == 0)
                write_register(ADDR_UNMAPPED, swma_pkg::PDATA_W'($urandom()));

            if (kind == 6)
                n = BIG_BURST;
            else
            begin
                n = $urandom_range(10, 30);
                if (w >= 1 && w <= 64)
                    n += w;
            end
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            repeat (n) send_sample(random_sample());
            sent += n;
            drain_results();
        end

        // anything arriving now has no sample behind it
        repeat (SETTLE_WAIT) @(posedge clk);
        if (boxcar.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/swma_pkg.sv
hdl/swma_ram.sv
hdl/swma_div.sv
hdl/sliding_window_moving_average.sv
dv/sliding_window_moving_average_tb.sv
